### src/cmpr_subblock_decode_defines.svh
// Assertion macros shared by the sub-block decoder RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef CMPR_SUBBLOCK_DECODE_DEFINES_SVH
`define CMPR_SUBBLOCK_DECODE_DEFINES_SVH

// Same-cycle implication: whenever ant holds, con must hold too.
`define CSD_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication: whenever ant holds, con must hold in the next cycle.
`define CSD_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

### src/csd_pkg.sv
// Shared types, constants and helper functions for the CMPR sub-block decoder.
// Used by csd_palette and cmpr_subblock_decode; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

    localparam int ColorWidth   = 16;
    localparam int IndexWidth   = 32;
    localparam int SubWidth     = 2;
    localparam int PixelWidth   = 32;
    localparam int InDataWidth  = 72;
    localparam int OutDataWidth = 136;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [1:0] ROW_LAST     = 2'd3;
    // 683 / 2048 approximates one third exactly for every sum below 2048.
    localparam logic [9:0] RECIP_THIRD  = 10'd683;

    typedef logic [PixelWidth-1:0] pixel_t;
    typedef pixel_t [3:0]          palette_t;

    function automatic logic [7:0] div_by_three(input logic [9:0] x);
        logic [19:0] prod;
        begin
            prod = x * RECIP_THIRD;
            return prod[18:11];
        end
    endfunction

    function automatic pixel_t pack_rgba(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
        return {r, g, b, a};
    endfunction

endpackage

`default_nettype wire

### src/cmpr_subblock_decode.sv
// Top level of the CMPR sub-block decoder: input register, row sequencer and
// output register. Depends on csd_pkg, csd_palette and the assertion header.
//
// Usage: each word on the slave stream carries one 4x4 sub-block (two RGB565
// endpoints, 32 index bits with pixel 0 in the top bits, and the sub-block's
// place in the 8x8 tile). The block answers with four words on the master
// stream, one per pixel row, top row first; tlast marks the fourth row.
// The palette is built in the cycle a word is accepted and held with the index
// bits; a two-bit row counter then walks the four rows into the output
// register, one row per cycle unless m_tready holds it, picking each pixel
// through a four-way select. The first row passes the hold registers and
// then the output register before m_tvalid shows it. The single output
// register moves one row per cycle unless m_tready holds it. A new word is
// accepted in the very cycle the fourth row of the previous one is loaded,
// so a steady stream runs without gaps.
// Stalls: while m_tready is low the output register holds its row and the row
// counter waits; s_tready drops once a sub-block is held and its rows are not
// all handed on.
// Reset (rst_n low, asynchronous) empties the held sub-block and the output
// register; no words are lost or invented afterwards.
`timescale 1ns / 1ps
`default_nettype none
`include "cmpr_subblock_decode_defines.svh"

module cmpr_subblock_decode
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // Fields from bit 0: color_a[15:0], color_b[31:16], index_bits[63:32],
    // sub_block[65:64], zero padding [71:66].
    input  wire logic [csd_pkg::InDataWidth-1:0]   s_tdata,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0: tile_row[2:0], column_half[3], pixel_zero[35:4],
    // pixel_one[67:36], pixel_two[99:68], pixel_three[131:100],
    // zero padding [135:132].
    output      logic [csd_pkg::OutDataWidth-1:0]  m_tdata,
    output      logic                              m_tlast
);
    import csd_pkg::*;

    palette_t                palette_in;
    palette_t                pal_reg;
    logic [IndexWidth-1:0]   idx_reg;
    logic [SubWidth-1:0]     sub_reg;
    logic [1:0]              row_reg;
    logic [1:0]              row_next;
    logic                    hold_valid_reg;
    logic                    hold_valid_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [2:0]              out_row_reg;
    logic                    out_half_reg;
    pixel_t [3:0]            out_pix_reg;
    logic                    out_last_reg;

    logic                    in_accept;
    logic                    out_load;
    logic                    hold_done;
    logic [7:0]              row_bits;
    pixel_t [3:0]            row_pix;

    csd_palette u_palette
    (
        .color_a (s_tdata[15:0]),
        .color_b (s_tdata[31:16]),
        .palette (palette_in)
    );

    // The output register takes a row whenever it is empty or being drained.
    assign out_load  = hold_valid_reg && (!out_valid_reg || m_tready);
    assign hold_done = out_load && (row_reg == ROW_LAST);
    assign s_tready  = !hold_valid_reg || hold_done;
    assign in_accept = s_tvalid && s_tready;

    // Row r uses index bits [31-8r -: 8]; ~row gives the top two bits of that bit index.
    assign row_bits = idx_reg[{~row_reg, 3'b111} -: 8];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            row_pix[c] = pal_reg[row_bits[7-2*c -: 2]];
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        row_next        = row_reg;
        if (in_accept)
        begin
            hold_valid_next = 1'b1;
            row_next        = 2'd0;
        end
        else if (hold_done)
        begin
            hold_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            row_next = row_reg + 2'd1;
        end
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            row_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            row_reg        <= row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pal_reg <= palette_in;
            idx_reg <= s_tdata[63:32];
            sub_reg <= s_tdata[65:64];
        end
        if (out_load)
        begin
            out_row_reg  <= {sub_reg[1], row_reg};
            out_half_reg <= sub_reg[0];
            out_pix_reg  <= row_pix;
            out_last_reg <= (row_reg == ROW_LAST);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_pix_reg[3], out_pix_reg[2], out_pix_reg[1],
                       out_pix_reg[0], out_half_reg, out_row_reg};

    // A new sub-block may only enter while the held one hands on its last row.
    `CSD_ASSERT_IMP(a_accept_only_when_free, in_accept && hold_valid_reg, hold_done,
                    "sub-block accepted while rows were still pending")
    // The last flag comes with the bottom row of the sub-block.
    `CSD_ASSERT_IMP(a_last_on_fourth_row, out_valid_reg && out_last_reg,
                    out_row_reg[1:0] == ROW_LAST, "tlast on a row other than the fourth")
    // After rows one to three the held sub-block must still be present.
    `CSD_ASSERT_NEXT(a_rows_continue, out_load && (row_reg != ROW_LAST),
                     hold_valid_reg && out_valid_reg, "sub-block dropped before its last row")

endmodule

`default_nettype wire

### src/csd_palette.sv
// Builds the four-entry RGBA palette from two RGB565 endpoints.
// Purely combinational; depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csd_palette
(
    input  wire logic [csd_pkg::ColorWidth-1:0] color_a,
    input  wire logic [csd_pkg::ColorWidth-1:0] color_b,
    output csd_pkg::palette_t                   palette
);
    import csd_pkg::*;

    logic [2:0][7:0] ea;
    logic [2:0][7:0] eb;
    logic [2:0][7:0] third_a;
    logic [2:0][7:0] third_b;
    logic [2:0][7:0] half;
    logic [2:0][9:0] sum_a;
    logic [2:0][9:0] sum_b;
    logic [2:0][8:0] sum_h;

    // Plain shift expansion, no bit replication.
    assign ea[0] = {color_a[15:11], 3'b000};
    assign ea[1] = {color_a[10:5], 2'b00};
    assign ea[2] = {color_a[4:0], 3'b000};
    assign eb[0] = {color_b[15:11], 3'b000};
    assign eb[1] = {color_b[10:5], 2'b00};
    assign eb[2] = {color_b[4:0], 3'b000};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_a[k]   = {1'b0, ea[k], 1'b0} + {2'b00, eb[k]};
            sum_b[k]   = {1'b0, eb[k], 1'b0} + {2'b00, ea[k]};
            sum_h[k]   = {1'b0, ea[k]} + {1'b0, eb[k]};
            third_a[k] = div_by_three(sum_a[k]);
            third_b[k] = div_by_three(sum_b[k]);
            half[k]    = sum_h[k][8:1];
        end

        palette[0] = pack_rgba(ea[0], ea[1], ea[2], ALPHA_OPAQUE);
        palette[1] = pack_rgba(eb[0], eb[1], eb[2], ALPHA_OPAQUE);
        if (color_a > color_b)
        begin
            palette[2] = pack_rgba(third_a[0], third_a[1], third_a[2], ALPHA_OPAQUE);
            palette[3] = pack_rgba(third_b[0], third_b[1], third_b[2], ALPHA_OPAQUE);
        end
        else
        begin
            // Equal endpoints land here too: average plus transparent black.
            palette[2] = pack_rgba(half[0], half[1], half[2], ALPHA_OPAQUE);
            palette[3] = '0;
        end
    end

endmodule

`default_nettype wire
